/* sv/saw_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and sizes for the stop-and-wait retransmit queue.
// No dependencies; every other file of the block imports this package.
package saw_pkg;

  // Ring size; the slot index is the 3-bit sequence number carried on the ports.
  localparam int unsigned QueueDepth = 8;
  localparam int unsigned IdxW       = $clog2(QueueDepth);
  // Lengths above this are clamped on enqueue.
  localparam int unsigned MaxLength  = 1023;
  // One more than the head walk can ever need; bounds the walk.
  localparam int unsigned GuardW     = $clog2(QueueDepth + 2);

  localparam int unsigned LenW  = 10;
  localparam int unsigned RefW  = 16;
  localparam int unsigned AttW  = 4;
  localparam int unsigned TickW = 16;
  localparam int unsigned CfgW  = 16;

  // Item kinds
  localparam logic [1:0] KIND_ENQ  = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_NACK = 2'd2;
  localparam logic [1:0] KIND_TICK = 2'd3;

  // Result events
  localparam logic [2:0] EV_ENQUEUED  = 3'd0;
  localparam logic [2:0] EV_FULL      = 3'd1;
  localparam logic [2:0] EV_SEND      = 3'd2;
  localparam logic [2:0] EV_DELIVERED = 3'd3;
  localparam logic [2:0] EV_DISCARDED = 3'd4;
  localparam logic [2:0] EV_EMPTY     = 3'd5;

  // Configuration register indexes
  localparam logic REG_MAX_ATTEMPTS = 1'b0;
  localparam logic REG_ACK_TIMEOUT  = 1'b1;

  localparam logic [AttW-1:0]  MaxAttemptsRst = AttW'(3);
  localparam logic [TickW-1:0] AckTimeoutRst  = TickW'(500);

  typedef struct packed {
    logic [1:0]      kind;
    logic [2:0]      seq;
    logic [RefW-1:0] payload_ref;
    logic [LenW-1:0] length;
  } item_t;

  typedef struct packed {
    logic [2:0]      event_res;
    logic [2:0]      out_seq;
    logic [RefW-1:0] out_ref;
    logic [LenW-1:0] out_length;
    logic [AttW-1:0] attempt;
    logic            last;
  } result_t;

  typedef struct packed {
    logic [LenW-1:0] length;
    logic [RefW-1:0] pref;
    logic [AttW-1:0] attempts;
    logic            acked;
    logic            nacked;
  } slot_t;

  typedef enum logic [2:0] {
    SW_NONE,
    SW_FILL,
    SW_RETIRE,
    SW_ACK,
    SW_NACK,
    SW_SEND
  } slot_op_e;

  typedef struct packed {
    slot_op_e        op;
    logic [AttW-1:0] attempts;
    logic [RefW-1:0] pref;
    logic [LenW-1:0] length;
  } slot_wr_t;

  typedef enum logic [2:0] {
    ACT_STOP,
    ACT_SKIP,
    ACT_DELIVER,
    ACT_DISCARD,
    ACT_SEND
  } head_act_e;

  typedef struct packed {
    head_act_e       act;
    logic [AttW-1:0] attempts_next;
  } head_step_t;

endpackage

/* sv/stop_and_wait_retransmit_queue.sv */
`timescale 1ns / 1ps
// Stop-and-wait ARQ sender: a ring of 8 pending messages whose slot index is
// the sequence number. An item enqueues a message, delivers an ack or nack, or
// counts one timer tick; then the head is walked one entry per cycle, while the
// output side can take results, through a shared step unit (retire acked, drop
// empty, discard spent, send/resend) until it waits, the ring is empty or a
// frame goes out; in_ready_o is high only between items. Results carry last=1
// on the final one of an item; an item may cause none (e.g. a tick while
// waiting). Config writes go straight to the registers and must happen while
// the block is idle.
// Depends on saw_pkg, saw_slot_store, saw_step_unit.
module stop_and_wait_retransmit_queue import saw_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  item_t           in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output result_t         out_item_o,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_INPUT = 4'b0010,
    S_HEAD  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [AttW-1:0]   max_att_q;
  logic [TickW-1:0]  timeout_q;
  logic [IdxW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [TickW-1:0]  wait_q, wait_d;
  logic [GuardW-1:0] guard_q, guard_d;
  item_t             item_q;

  // One result is held back so the final one of an item can get last=1.
  result_t pend_q, pend_d;
  logic    pend_vld_q, pend_vld_d;
  result_t out_q, out_d;
  logic    out_vld_q, out_vld_d;

  logic       out_free;
  logic [IdxW-1:0] addr;
  slot_wr_t   wr;
  slot_t      slot;
  head_step_t step;
  logic       in_fire;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;
  assign out_free    = !out_vld_q || out_ready_i;

  // Enqueue looks at the tail slot, everything else at the head slot.
  assign addr = (state_q == S_INPUT && item_q.kind == KIND_ENQ) ? tail_q : head_q;

  saw_slot_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .addr_i (addr),
    .wr_i   (wr),
    .rd_o   (slot)
  );

  saw_step_unit u_step (
    .slot_i         (slot),
    .at_tail_i      (head_q == tail_q),
    .wait_busy_i    (wait_q != '0),
    .max_attempts_i (max_att_q),
    .step_o         (step)
  );

  always_comb begin
    result_t         res;
    logic            emit;
    logic            can_emit;
    logic [LenW-1:0] len_clamped;

    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    wait_d     = wait_q;
    guard_d    = guard_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    wr         = '{op: SW_NONE, attempts: '0, pref: '0, length: '0};
    res        = '0;
    emit       = 1'b0;
    can_emit   = !pend_vld_q || out_free;

    if ({7'd0, item_q.length} > 17'(MaxLength)) begin
      len_clamped = LenW'(MaxLength);
    end else begin
      len_clamped = item_q.length;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_INPUT;
        end
      end

      S_INPUT: begin
        // pend is always empty here
        guard_d = '0;
        state_d = S_HEAD;
        unique case (item_q.kind)
          KIND_ENQ: begin
            pend_vld_d     = 1'b1;
            pend_d         = '0;
            pend_d.out_seq = tail_q;
            if (tail_q == head_q && slot.length != '0) begin
              pend_d.event_res = EV_FULL;
            end else begin
              pend_d.event_res = EV_ENQUEUED;
              wr.op            = SW_FILL;
              wr.pref          = item_q.payload_ref;
              wr.length        = len_clamped;
              tail_d           = tail_q + IdxW'(1);
            end
          end
          KIND_ACK, KIND_NACK: begin
            if (item_q.seq == head_q) begin
              wr.op = (item_q.kind == KIND_ACK) ? SW_ACK : SW_NACK;
            end
          end
          KIND_TICK: begin
            if (wait_q != '0) begin
              wait_d = wait_q - TickW'(1);
            end
          end
          default: ;
        endcase
      end

      S_HEAD: begin
        res.out_seq = head_q;
        if (guard_q == GuardW'(QueueDepth + 1)) begin
          state_d = pend_vld_q ? S_FLUSH : S_IDLE;
        end else begin
          unique case (step.act)
            ACT_STOP: state_d = pend_vld_q ? S_FLUSH : S_IDLE;
            ACT_SKIP: begin
              res.event_res = EV_EMPTY;
              if (can_emit) begin
                emit    = 1'b1;
                head_d  = head_q + IdxW'(1);
                guard_d = guard_q + GuardW'(1);
              end
            end
            ACT_DELIVER, ACT_DISCARD: begin
              res.event_res = (step.act == ACT_DELIVER) ? EV_DELIVERED : EV_DISCARDED;
              if (can_emit) begin
                emit    = 1'b1;
                wr.op   = SW_RETIRE;
                head_d  = head_q + IdxW'(1);
                guard_d = guard_q + GuardW'(1);
              end
            end
            ACT_SEND: begin
              res.event_res  = EV_SEND;
              res.out_ref    = slot.pref;
              res.out_length = slot.length;
              res.attempt    = step.attempts_next;
              if (can_emit) begin
                emit        = 1'b1;
                wr.op       = SW_SEND;
                wr.attempts = step.attempts_next;
                wait_d      = timeout_q;
                state_d     = S_FLUSH;
              end
            end
            default: ;
          endcase
        end
        if (emit) begin
          // previous held result is not the final one
          if (pend_vld_q) begin
            out_d      = pend_q;
            out_d.last = 1'b0;
            out_vld_d  = 1'b1;
          end
          pend_d     = res;
          pend_vld_d = 1'b1;
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          out_d      = pend_q;
          out_d.last = 1'b1;
          out_vld_d  = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      max_att_q  <= MaxAttemptsRst;
      timeout_q  <= AckTimeoutRst;
      head_q     <= '0;
      tail_q     <= '0;
      wait_q     <= '0;
      guard_q    <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      wait_q     <= wait_d;
      guard_q    <= guard_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MAX_ATTEMPTS: max_att_q <= cfg_data_i[AttW-1:0];
          REG_ACK_TIMEOUT:  timeout_q <= cfg_data_i[TickW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_item_i;
    end
    pend_q <= pend_d;
    out_q  <= out_d;
  end

endmodule

/* sv/saw_slot_store.sv */
`timescale 1ns / 1ps
// Slot storage of the ring: length, handle, attempt count and ack/nack flags.
// Depends on saw_pkg.
module saw_slot_store import saw_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [IdxW-1:0] addr_i,
  input  slot_wr_t        wr_i,
  output slot_t           rd_o
);

  logic [LenW-1:0] len_q    [QueueDepth];
  logic [RefW-1:0] pref_q   [QueueDepth];
  logic [AttW-1:0] att_q    [QueueDepth];
  logic            acked_q  [QueueDepth];
  logic            nacked_q [QueueDepth];

  assign rd_o.length   = len_q[addr_i];
  assign rd_o.pref     = pref_q[addr_i];
  assign rd_o.attempts = att_q[addr_i];
  assign rd_o.acked    = acked_q[addr_i];
  assign rd_o.nacked   = nacked_q[addr_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QueueDepth; i++) begin
        len_q[i]    <= '0;
        att_q[i]    <= '0;
        acked_q[i]  <= 1'b0;
        nacked_q[i] <= 1'b0;
      end
    end else begin
      unique case (wr_i.op)
        SW_FILL: begin
          len_q[addr_i]    <= wr_i.length;
          att_q[addr_i]    <= '0;
          acked_q[addr_i]  <= 1'b0;
          nacked_q[addr_i] <= 1'b0;
        end
        SW_RETIRE: len_q[addr_i]    <= '0;
        SW_ACK:    acked_q[addr_i]  <= 1'b1;
        SW_NACK:   nacked_q[addr_i] <= 1'b1;
        SW_SEND: begin
          att_q[addr_i]    <= wr_i.attempts;
          nacked_q[addr_i] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Handle is undefined until written; no reset.
  always_ff @(posedge clk_i) begin
    if (wr_i.op == SW_FILL) begin
      pref_q[addr_i] <= wr_i.pref;
    end
  end

endmodule

/* sv/saw_step_unit.sv */
`timescale 1ns / 1ps
// Decision for one step of the head walk: compare and increment of attempts.
// Depends on saw_pkg.
module saw_step_unit import saw_pkg::*; (
  input  slot_t           slot_i,
  input  logic            at_tail_i,
  input  logic            wait_busy_i,
  input  logic [AttW-1:0] max_attempts_i,
  output head_step_t      step_o
);

  always_comb begin
    step_o.attempts_next = slot_i.attempts + AttW'(1);
    priority if (slot_i.length == '0) begin
      step_o.act = at_tail_i ? ACT_STOP : ACT_SKIP;
    end else if (slot_i.acked) begin
      step_o.act = ACT_DELIVER;
    end else if (slot_i.attempts != '0 && !slot_i.nacked && wait_busy_i) begin
      step_o.act = ACT_STOP;      // frame out, still waiting
    end else if (slot_i.attempts >= max_attempts_i) begin
      step_o.act = ACT_DISCARD;
    end else begin
      step_o.act = ACT_SEND;
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for stop_and_wait_retransmit_queue. It drives items with random
// gaps and output stalls, predicts every result, and checks each result in order.
// Depends on saw_pkg and the block's RTL.
module testbench;
  import saw_pkg::*;

  localparam int unsigned SettleCycles = 24;
  localparam int unsigned DrainLimit   = 6000;
  localparam int unsigned MaxGap       = 12;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  item_t           in_item;
  logic            out_valid;
  logic            out_ready;
  result_t         out_item;
  logic            cfg_we;
  logic            cfg_idx;
  logic [CfgW-1:0] cfg_data;

  int unsigned fail_count = 0;
  bit          tx_idle_on;
  bit          rx_idle_on;
  int unsigned rx_hold_cycles = 0;   // one-shot long hold taken by the receiver

  // Predicted sender state
  logic [LenW-1:0]  ring_len    [QueueDepth];
  logic [RefW-1:0]  ring_ref    [QueueDepth];
  logic [AttW-1:0]  ring_att    [QueueDepth];
  logic             ring_acked  [QueueDepth];
  logic             ring_nacked [QueueDepth];
  logic [IdxW-1:0]  ring_head;
  logic [IdxW-1:0]  ring_tail;
  logic [TickW-1:0] ticks_left;
  logic [AttW-1:0]  cfg_max_att;
  logic [TickW-1:0] cfg_timeout;

  result_t awaited_results[$];

  stop_and_wait_retransmit_queue uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_ring();
    for (int i = 0; i < QueueDepth; i++) begin
      ring_len[i]    = '0;
      ring_ref[i]    = '0;
      ring_att[i]    = '0;
      ring_acked[i]  = 1'b0;
      ring_nacked[i] = 1'b0;
    end
    ring_head   = '0;
    ring_tail   = '0;
    ticks_left  = '0;
    cfg_max_att = MaxAttemptsRst;
    cfg_timeout = AckTimeoutRst;
  endfunction

  function automatic result_t make_result(input logic [2:0] ev, input logic [IdxW-1:0] slot,
                                          input logic [RefW-1:0] pref,
                                          input logic [LenW-1:0] len,
                                          input logic [AttW-1:0] att);
    result_t r;
    r.event_res  = ev;
    r.out_seq    = slot;
    r.out_ref    = pref;
    r.out_length = len;
    r.attempt    = att;
    r.last       = 1'b0;
    return r;
  endfunction

  // Applies one accepted item and queues the results it causes.
  function automatic void predict_arq_step(input item_t it);
    result_t         batch[$];
    result_t         r;
    logic [IdxW-1:0] h;
    bit              walking;
    walking = 1'b1;
    case (it.kind)
      KIND_ENQ: begin
        if (ring_tail == ring_head && ring_len[ring_tail] != '0) begin
          batch.push_back(make_result(EV_FULL, ring_tail, '0, '0, '0));
        end else begin
          // the length field cannot exceed MaxLength, so no clamp is needed
          ring_len[ring_tail]    = it.length;
          ring_ref[ring_tail]    = it.payload_ref;
          ring_att[ring_tail]    = '0;
          ring_acked[ring_tail]  = 1'b0;
          ring_nacked[ring_tail] = 1'b0;
          batch.push_back(make_result(EV_ENQUEUED, ring_tail, '0, '0, '0));
          ring_tail = ring_tail + IdxW'(1);
        end
      end
      KIND_ACK: begin
        if (it.seq == ring_head) ring_acked[ring_head] = 1'b1;
      end
      KIND_NACK: begin
        if (it.seq == ring_head) ring_nacked[ring_head] = 1'b1;
      end
      default: begin
        if (ticks_left != '0) ticks_left = ticks_left - TickW'(1);
      end
    endcase

    // Head walk: drop empties, retire acked or spent entries, stop on wait or send.
    for (int g = 0; g <= QueueDepth && walking; g++) begin
      h = ring_head;
      if (ring_len[h] == '0) begin
        if (h == ring_tail) begin
          walking = 1'b0;
        end else begin
          batch.push_back(make_result(EV_EMPTY, h, '0, '0, '0));
          ring_head = h + IdxW'(1);
        end
      end else if (ring_acked[h]) begin
        batch.push_back(make_result(EV_DELIVERED, h, '0, '0, '0));
        ring_len[h] = '0;
        ring_head   = h + IdxW'(1);
      end else if (ring_att[h] != '0 && !ring_nacked[h] && ticks_left != '0) begin
        walking = 1'b0;
      end else if (ring_att[h] >= cfg_max_att) begin
        batch.push_back(make_result(EV_DISCARDED, h, '0, '0, '0));
        ring_len[h] = '0;
        ring_head   = h + IdxW'(1);
      end else begin
        ring_att[h]    = ring_att[h] + AttW'(1);
        ring_nacked[h] = 1'b0;
        ticks_left     = cfg_timeout;
        batch.push_back(make_result(EV_SEND, h, ring_ref[h], ring_len[h], ring_att[h]));
        walking = 1'b0;
      end
    end

    foreach (batch[i]) begin
      r      = batch[i];
      r.last = (i == batch.size() - 1);
      awaited_results.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: event_res %0d out_seq %0d", out_item.event_res,
               out_item.out_seq);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("event_res", 16'(want.event_res), 16'(out_item.event_res));
        check_field("out_seq", 16'(want.out_seq), 16'(out_item.out_seq));
        check_field("out_ref", want.out_ref, out_item.out_ref);
        check_field("out_length", 16'(want.out_length), 16'(out_item.out_length));
        check_field("attempt", 16'(want.attempt), 16'(out_item.attempt));
        check_field("last", 16'(want.last), 16'(out_item.last));
      end
    end
  end

  // Receiver: per result a random stall, or a long one-shot hold when requested.
  initial begin : result_receiver
    int unsigned stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_cycles != 0) begin
        stall          = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = rx_idle_on ? $urandom_range(0, MaxGap) : 0;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Offers one item after a random gap and returns at the edge it is taken.
  task automatic send_item(input item_t it);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, MaxGap) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_arq_step(it);
  endtask

  // Stops offering, waits for all expected results, then lets the block settle.
  task automatic drain();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    while (awaited_results.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    if (awaited_results.size() != 0) begin
      $error("%0d expected results never arrived", awaited_results.size());
      fail_count++;
      awaited_results.delete();
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CfgW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == REG_MAX_ATTEMPTS) cfg_max_att = data[AttW-1:0];
    else cfg_timeout = data[TickW-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Upper data bits are junk; only the low four bits hold the attempt limit.
  task automatic set_limits(input logic [AttW-1:0] attempts, input logic [TickW-1:0] timeout);
    logic [CfgW-1:0] data;
    data            = CfgW'($urandom);
    data[AttW-1:0]  = attempts;
    write_reg(REG_MAX_ATTEMPTS, data);
    write_reg(REG_ACK_TIMEOUT, timeout);
  endtask

  function automatic item_t mk_item(input logic [1:0] kind, input logic [2:0] seq,
                                    input logic [RefW-1:0] pref, input logic [LenW-1:0] len);
    item_t it;
    it.kind        = kind;
    it.seq         = seq;
    it.payload_ref = pref;
    it.length      = len;
    return it;
  endfunction

  function automatic item_t random_item(input int unsigned enq_pct);
    item_t       it;
    int unsigned roll;
    it.seq         = IdxW'($urandom);
    it.payload_ref = RefW'($urandom);
    roll = $urandom_range(0, 19);
    if (roll == 0) it.length = '0;
    else if (roll == 1) it.length = LenW'(MaxLength);
    else it.length = LenW'($urandom_range(1, MaxLength));
    roll = $urandom_range(0, 99);
    if (roll < enq_pct) begin
      it.kind = KIND_ENQ;
    end else begin
      roll = $urandom_range(0, 9);
      if (roll < 4) it.kind = KIND_ACK;
      else if (roll < 6) it.kind = KIND_NACK;
      else it.kind = KIND_TICK;
      // most acks and nacks answer the frame in flight
      if (it.kind != KIND_TICK && $urandom_range(0, 99) < 85) it.seq = ring_head;
    end
    return it;
  endfunction

  // ---------------------------------------------------------------- tests

  // Reset limits: field extremes, stray and matching acks/nacks, empty drop, full ring.
  task automatic test_directed();
    send_item(mk_item(KIND_ENQ, 3'd0, 16'hFFFF, LenW'(MaxLength)));
    send_item(mk_item(KIND_ENQ, 3'd7, 16'h0000, '0));        // zero length
    send_item(mk_item(KIND_ACK, 3'd5, 16'h1234, 10'd1));     // other sequence
    send_item(mk_item(KIND_NACK, 3'd0, 16'h0000, '0));       // resend at once
    send_item(mk_item(KIND_TICK, 3'd7, 16'hFFFF, 10'h3FF));
    send_item(mk_item(KIND_ACK, 3'd0, 16'h0000, '0));        // deliver, then drop empty
    send_item(mk_item(KIND_ACK, 3'd2, 16'h0000, '0));        // ack on a free head slot
    send_item(mk_item(KIND_ENQ, 3'd0, 16'h5A5A, 10'd1));     // clears the stale flag
    repeat (3) send_item(mk_item(KIND_NACK, 3'd2, 16'hA5A5, 10'h2AA)); // out of attempts
    for (int i = 0; i < 9; i++) begin                        // last one finds the ring full
      send_item(mk_item(KIND_ENQ, 3'(i), RefW'($urandom), LenW'($urandom_range(1, 1023))));
    end
    drain();
  endtask

  // Limit lowered below the attempts already used by the head entry.
  task automatic test_lowered_limit();
    set_limits(4'd15, 16'hFFFF);
    repeat (4) send_item(mk_item(KIND_NACK, ring_head, RefW'($urandom), '0));
    send_item(mk_item(KIND_TICK, '0, '0, '0));
    drain();
    set_limits(4'd2, 16'hFFFF);
    send_item(mk_item(KIND_NACK, ring_head, RefW'($urandom), '0));
    drain();
  endtask

  task automatic run_phase(input logic [AttW-1:0] attempts, input logic [TickW-1:0] timeout,
                           input bit tx_idle, input bit rx_idle, input int unsigned count);
    tx_idle_on = tx_idle;
    rx_idle_on = rx_idle;
    set_limits(attempts, timeout);
    repeat (count) send_item(random_item(35));
    drain();
  endtask

  task automatic test_random_phases();
    run_phase(4'd3, 16'd4, 1'b1, 1'b1, 80);
    run_phase(4'd1, 16'd1, 1'b1, 1'b0, 50);
    run_phase(4'd15, 16'd2, 1'b0, 1'b1, 60);
    run_phase(4'd0, 16'd3, 1'b0, 1'b0, 30);         // nothing is ever sent
    run_phase(4'd4, 16'd0, 1'b1, 1'b1, 50);         // unanswered frames resend on any item
    run_phase(4'd15, 16'hFFFF, 1'b1, 1'b1, 40);
    run_phase(4'd7, 16'd6, 1'b1, 1'b1, 60);
  endtask

  // Long receiver hold with the sender pushing enqueues, then a full pause.
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    set_limits(4'd5, 16'd3);
    rx_hold_cycles = 300;
    repeat (30) send_item(random_item(70));
    drain();
    rx_idle_on = 1'b1;
    repeat (12) send_item(random_item(40));
    drain();
    tx_idle_on = 1'b1;
    repeat (12) send_item(random_item(40));
  endtask

  initial begin : run_tests
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_item    <= '0;
    cfg_we     <= 1'b0;
    cfg_idx    <= REG_MAX_ATTEMPTS;
    cfg_data   <= '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    clear_ring();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_lowered_limit();
    test_random_phases();
    test_backpressure();
    drain();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/saw_pkg.sv
sv/saw_slot_store.sv
sv/saw_step_unit.sv
sv/stop_and_wait_retransmit_queue.sv
tb/sv/testbench.sv
